>>> hdl/segment_box_clip_3d_assert.svh
// Assertion macros shared by the clipper RTL.
`ifndef SEGMENT_BOX_CLIP_3D_ASSERT_SVH
`define SEGMENT_BOX_CLIP_3D_ASSERT_SVH

// Same-cycle implication, disabled while rst_sig is high.
`define SBC3_ASSERT_IMPLY(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("clipper assertion failed");

// Next-cycle implication, disabled while rst_sig is high.
`define SBC3_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
  label: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("clipper assertion failed");

`endif

>>> hdl/sbc3_pkg.sv
`timescale 1ns / 1ps
package sbc3_pkg;

  localparam int COORD_W   = 32;
  localparam int NUM_AXES  = 3;
  localparam int DIV_STEPS = COORD_W;
  // Decide, magnitudes, product, divider steps, final add.
  localparam int UNIT_LAT  = DIV_STEPS + 4;
  localparam int NUM_UNITS = 2 * NUM_AXES;
  localparam int TOTAL_LAT = NUM_UNITS * UNIT_LAT + 1;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic                                ok;
    logic                                dir;
    logic [NUM_AXES-1:0][COORD_W-1:0]    s;
    logic [NUM_AXES-1:0][COORD_W-1:0]    e;
  } seg_t;

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

endpackage

>>> hdl/sbc3_clip_unit.sv
`timescale 1ns / 1ps
module sbc3_clip_unit import sbc3_pkg::*; #(
  parameter int AXIS   = 0,
  parameter bit SECOND = 1'b0
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  seg_t   in_seg,
  input  coord_t lo,
  input  coord_t hi,
  output logic   out_valid,
  output seg_t   out_seg
);

  // Decision stage.
  logic   dir_c, ok_c, mv_c, dste_c;
  coord_t bound_c, sa, ea;
  seg_t   dseg_c;
  logic   d_valid, d_mv, d_dste;
  seg_t   d_seg;
  coord_t d_bound;

  assign sa = $signed(in_seg.s[AXIS]);
  assign ea = $signed(in_seg.e[AXIS]);

  always_comb begin
    if (!SECOND) begin
      dir_c   = (sa <= ea);
      ok_c    = in_seg.ok && !(lo > hi) &&
                (dir_c ? !(ea < lo || sa > hi) : !(sa < lo || ea > hi));
      mv_c    = ok_c && (dir_c ? (sa < lo) : (ea < lo));
      dste_c  = !dir_c;
      bound_c = lo;
    end else begin
      dir_c   = in_seg.dir;
      ok_c    = in_seg.ok;
      mv_c    = ok_c && (dir_c ? (ea > hi) : (sa > hi));
      dste_c  = dir_c;
      bound_c = hi;
    end
    dseg_c     = in_seg;
    dseg_c.ok  = ok_c;
    dseg_c.dir = dir_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else begin
      d_valid <= in_valid;
    end
    d_seg   <= dseg_c;
    d_mv    <= mv_c;
    d_dste  <= dste_c;
    d_bound <= bound_c;
  end

  // Magnitude stage: differences, their signs and absolute values.
  logic [COORD_W:0]   num_c, den_c;
  logic [COORD_W:0]   dif_c [NUM_AXES];
  logic               m_valid, m_mv, m_dste;
  seg_t               m_seg;
  logic [COORD_W-1:0] m_dmag [NUM_AXES];
  logic               m_neg  [NUM_AXES];
  logic [COORD_W-1:0] m_nmag, m_den;

  assign num_c = {d_bound[COORD_W-1], d_bound} -
                 {d_seg.s[AXIS][COORD_W-1], d_seg.s[AXIS]};
  assign den_c = {d_seg.e[AXIS][COORD_W-1], d_seg.e[AXIS]} -
                 {d_seg.s[AXIS][COORD_W-1], d_seg.s[AXIS]};

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_mag
    assign dif_c[k] = {d_seg.e[k][COORD_W-1], d_seg.e[k]} -
                      {d_seg.s[k][COORD_W-1], d_seg.s[k]};
    always_ff @(posedge clk) begin
      m_dmag[k] <= dif_c[k][COORD_W] ? COORD_W'(-dif_c[k]) : dif_c[k][COORD_W-1:0];
      m_neg[k]  <= dif_c[k][COORD_W] ^ num_c[COORD_W] ^ den_c[COORD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else begin
      m_valid <= d_valid;
    end
    m_seg  <= d_seg;
    m_mv   <= d_mv;
    m_dste <= d_dste;
    m_nmag <= num_c[COORD_W] ? COORD_W'(-num_c) : num_c[COORD_W-1:0];
    m_den  <= den_c[COORD_W] ? COORD_W'(-den_c) : den_c[COORD_W-1:0];
  end

  // Product stage feeds slot 0 of the divider line. The high half of each
  // product is below the divisor, so it seeds the partial remainder.
  logic               v_q    [DIV_STEPS+1];
  seg_t               seg_q  [DIV_STEPS+1];
  logic               mv_q   [DIV_STEPS+1];
  logic               dste_q [DIV_STEPS+1];
  logic [COORD_W-1:0] den_q  [DIV_STEPS+1];
  logic               neg_q  [DIV_STEPS+1][NUM_AXES];
  logic [COORD_W-1:0] rem_q  [DIV_STEPS+1][NUM_AXES];
  logic [COORD_W-1:0] low_q  [DIV_STEPS+1][NUM_AXES];

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_prod
    logic [2*COORD_W-1:0] prod;
    assign prod = m_dmag[k] * m_nmag;
    always_ff @(posedge clk) begin
      rem_q[0][k] <= prod[2*COORD_W-1:COORD_W];
      low_q[0][k] <= prod[COORD_W-1:0];
      neg_q[0][k] <= m_neg[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= m_valid;
    end
    seg_q[0]  <= m_seg;
    mv_q[0]   <= m_mv;
    dste_q[0] <= m_dste;
    den_q[0]  <= m_den;
  end

  // Restoring divider, one quotient bit per stage. Quotient bits shift in
  // at the bottom of the low word as the dividend bits leave at the top.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    for (genvar k = 0; k < NUM_AXES; k++) begin : g_lane
      logic [COORD_W:0] trial;
      logic             fits;
      assign trial = {rem_q[i][k], low_q[i][k][COORD_W-1]};
      assign fits  = (trial >= {1'b0, den_q[i]});
      always_ff @(posedge clk) begin
        rem_q[i+1][k] <= fits ? COORD_W'(trial - {1'b0, den_q[i]}) : trial[COORD_W-1:0];
        low_q[i+1][k] <= {low_q[i][k][COORD_W-2:0], fits};
        neg_q[i+1][k] <= neg_q[i][k];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
      seg_q[i+1]  <= seg_q[i];
      mv_q[i+1]   <= mv_q[i];
      dste_q[i+1] <= dste_q[i];
      den_q[i+1]  <= den_q[i];
    end
  end

  // Final stage: apply the sign, add to the start point, replace one end.
  logic [NUM_AXES-1:0][COORD_W-1:0] pt_c;
  seg_t                             seg_c;

  for (genvar k = 0; k < NUM_AXES; k++) begin : g_fin
    logic [COORD_W:0] qs, sum;
    assign qs  = neg_q[DIV_STEPS][k] ? (COORD_W+1)'(-{1'b0, low_q[DIV_STEPS][k]})
                                     : {1'b0, low_q[DIV_STEPS][k]};
    assign sum = {seg_q[DIV_STEPS].s[k][COORD_W-1], seg_q[DIV_STEPS].s[k]} + qs;
    assign pt_c[k] = sum[COORD_W-1:0];
  end

  always_comb begin
    seg_c = seg_q[DIV_STEPS];
    if (mv_q[DIV_STEPS]) begin
      if (dste_q[DIV_STEPS]) begin
        seg_c.e = pt_c;
      end else begin
        seg_c.s = pt_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= v_q[DIV_STEPS];
    end
    out_seg <= seg_c;
  end

endmodule

>>> hdl/segment_box_clip_3d.sv
`timescale 1ns / 1ps
// Throughput: one segment per cycle; busy is high only while rst is high.
// Six clip units (lower then upper bound for x, y, z) run in a chain, each 36
// stages deep, most of it a 32-step restoring divider; one output register.
// Reset is synchronous: it clears all valid bits and loads the empty box.
// Results cannot be stalled; each one is shown for exactly one cycle.
`include "segment_box_clip_3d_assert.svh"
module segment_box_clip_3d import sbc3_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  // Command channel: a beat is taken when start is high and busy is low.
  input  logic         start,
  output logic         busy,
  input  coord_t       start_x,
  input  coord_t       start_y,
  input  coord_t       start_z,
  input  coord_t       end_x,
  input  coord_t       end_y,
  input  coord_t       end_z,
  // Box registers, written whenever cfg_we is high outside reset.
  input  logic         cfg_we,
  input  logic [2:0]   cfg_addr,
  input  logic [31:0]  cfg_wdata,
  // Result beat, valid for the single cycle in which done is high.
  output logic         done,
  output logic         accepted,
  output coord_t       clip_start_x,
  output coord_t       clip_start_y,
  output coord_t       clip_start_z,
  output coord_t       clip_end_x,
  output coord_t       clip_end_y,
  output coord_t       clip_end_z
);

  // The box. Reset puts every lower bound above its upper bound, so the box
  // is empty and every segment is rejected on the x axis.
  coord_t box_lo [NUM_AXES];
  coord_t box_hi [NUM_AXES];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        box_lo[k] <= {1'b0, {(COORD_W-1){1'b1}}};
        box_hi[k] <= {1'b1, {(COORD_W-1){1'b0}}};
      end
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_addr))
        REG_MIN_X: box_lo[0] <= cfg_wdata;
        REG_MIN_Y: box_lo[1] <= cfg_wdata;
        REG_MIN_Z: box_lo[2] <= cfg_wdata;
        REG_MAX_X: box_hi[0] <= cfg_wdata;
        REG_MAX_Y: box_hi[1] <= cfg_wdata;
        REG_MAX_Z: box_hi[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The pipeline never stalls, so the only time a beat is refused is reset.
  logic acc_in;
  assign busy   = rst;
  assign acc_in = start && !busy;

  // Segment chain between the clip units. Entry 0 is the raw input beat.
  logic chain_v   [NUM_UNITS+1];
  seg_t chain_seg [NUM_UNITS+1];

  assign chain_v[0]       = acc_in;
  assign chain_seg[0].ok  = 1'b1;
  assign chain_seg[0].dir = 1'b0;
  assign chain_seg[0].s   = {start_z, start_y, start_x};
  assign chain_seg[0].e   = {end_z, end_y, end_x};

  // On each axis the first unit rejects or clips against the lower bound,
  // the second clips the already shortened segment against the upper bound.
  for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
    for (genvar p = 0; p < 2; p++) begin : g_side
      sbc3_clip_unit #(
        .AXIS   (a),
        .SECOND (p == 1)
      ) u_clip (
        .clk       (clk),
        .rst       (rst),
        .in_valid  (chain_v[2*a+p]),
        .in_seg    (chain_seg[2*a+p]),
        .lo        (box_lo[a]),
        .hi        (box_hi[a]),
        .out_valid (chain_v[2*a+p+1]),
        .out_seg   (chain_seg[2*a+p+1])
      );
    end
  end

  // Output register. A rejected segment reports all coordinates as zero.
  seg_t fin;
  assign fin = chain_seg[NUM_UNITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_v[NUM_UNITS];
    end
    accepted     <= fin.ok;
    clip_start_x <= fin.ok ? $signed(fin.s[0]) : '0;
    clip_start_y <= fin.ok ? $signed(fin.s[1]) : '0;
    clip_start_z <= fin.ok ? $signed(fin.s[2]) : '0;
    clip_end_x   <= fin.ok ? $signed(fin.e[0]) : '0;
    clip_end_y   <= fin.ok ? $signed(fin.e[1]) : '0;
    clip_end_z   <= fin.ok ? $signed(fin.e[2]) : '0;
  end

  // All six output coordinates are zero.
  logic coords_zero;
  assign coords_zero = (clip_start_x == '0) && (clip_start_y == '0) &&
                       (clip_start_z == '0) && (clip_end_x == '0) &&
                       (clip_end_y == '0) && (clip_end_z == '0);

  // Every result traces back to a beat taken exactly the pipeline depth ago.
  `SBC3_ASSERT_IMPLY(a_latency, clk, rst, done, $past(acc_in, TOTAL_LAT))
  // A rejected segment carries no coordinates.
  `SBC3_ASSERT_IMPLY(a_reject_zero, clk, rst, done && !accepted, coords_zero)
  // Reset flushes every beat in flight.
  `SBC3_ASSERT_NEXT(a_reset_flush, clk, 1'b0, rst, !done)

endmodule

>>> tb/sv/segment_box_clip_3d_checker.sv
`timescale 1ns / 1ps
module segment_box_clip_3d_checker import sbc3_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  coord_t      start_x,
  input  coord_t      start_y,
  input  coord_t      start_z,
  input  coord_t      end_x,
  input  coord_t      end_y,
  input  coord_t      end_z,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        done,
  input  logic        accepted,
  input  coord_t      clip_start_x,
  input  coord_t      clip_start_y,
  input  coord_t      clip_start_z,
  input  coord_t      clip_end_x,
  input  coord_t      clip_end_y,
  input  coord_t      clip_end_z,
  output int          fails,
  output int          pending
);

  typedef struct {
    logic        ok;
    logic [31:0] cs [3];
    logic [31:0] ce [3];
  } clip_t;

  longint box_lo [3];
  longint box_hi [3];
  clip_t  clip_q [$];

  function automatic logic [63:0] magn(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // trunc(d * num / den), exact through a wide product.
  function automatic longint scaled(longint d, longint num, longint den);
    logic [127:0] prod;
    logic [127:0] quo;
    logic neg;
    neg = ((d < 0) != (num < 0)) != (den < 0);
    if (d == 0 || num == 0) return 0;
    prod = 128'(magn(d)) * 128'(magn(num));
    quo = prod / 128'(magn(den));
    return neg ? -longint'(quo[63:0]) : longint'(quo[63:0]);
  endfunction

  function automatic void slide(ref longint p [3], input longint s [3], input longint e [3],
                                input int a, input longint bound);
    longint tmp [3];
    for (int k = 0; k < 3; k++)
      tmp[k] = s[k] + scaled(e[k] - s[k], bound - s[a], e[a] - s[a]);
    p = tmp;
  endfunction

  function automatic clip_t clip_segment(longint s [3], longint e [3]);
    clip_t r;
    logic ok;
    ok = 1'b1;
    for (int a = 0; a < 3 && ok; a++) begin
      if (box_lo[a] > box_hi[a]) begin
        ok = 1'b0;
      end else if (s[a] <= e[a]) begin
        if (e[a] < box_lo[a] || s[a] > box_hi[a]) begin
          ok = 1'b0;
        end else begin
          if (s[a] < box_lo[a]) slide(s, s, e, a, box_lo[a]);
          if (e[a] > box_hi[a]) slide(e, s, e, a, box_hi[a]);
        end
      end else begin
        if (s[a] < box_lo[a] || e[a] > box_hi[a]) begin
          ok = 1'b0;
        end else begin
          if (e[a] < box_lo[a]) slide(e, s, e, a, box_lo[a]);
          if (s[a] > box_hi[a]) slide(s, s, e, a, box_hi[a]);
        end
      end
    end
    r.ok = ok;
    for (int k = 0; k < 3; k++) begin
      r.cs[k] = ok ? s[k][31:0] : 32'd0;
      r.ce[k] = ok ? e[k][31:0] : 32'd0;
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    fails++;
  endtask

  always @(posedge clk) begin
    longint s [3];
    longint e [3];
    clip_t want;
    if (rst) begin
      for (int k = 0; k < 3; k++) begin
        box_lo[k] = 64'sh7FFF_FFFF;
        box_hi[k] = -64'sh8000_0000;
      end
      clip_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIN_X: box_lo[0] = longint'(signed'(cfg_wdata));
          REG_MIN_Y: box_lo[1] = longint'(signed'(cfg_wdata));
          REG_MIN_Z: box_lo[2] = longint'(signed'(cfg_wdata));
          REG_MAX_X: box_hi[0] = longint'(signed'(cfg_wdata));
          REG_MAX_Y: box_hi[1] = longint'(signed'(cfg_wdata));
          REG_MAX_Z: box_hi[2] = longint'(signed'(cfg_wdata));
          default: ;
        endcase
      end
      if (done) begin
        if (clip_q.size() == 0) begin
          report("result with nothing outstanding", 32'(accepted), 32'd0);
        end else begin
          want = clip_q.pop_front();
          if (accepted !== want.ok) report("accepted", 32'(accepted), 32'(want.ok));
          if (clip_start_x !== want.cs[0]) report("clip_start_x", clip_start_x, want.cs[0]);
          if (clip_start_y !== want.cs[1]) report("clip_start_y", clip_start_y, want.cs[1]);
          if (clip_start_z !== want.cs[2]) report("clip_start_z", clip_start_z, want.cs[2]);
          if (clip_end_x !== want.ce[0]) report("clip_end_x", clip_end_x, want.ce[0]);
          if (clip_end_y !== want.ce[1]) report("clip_end_y", clip_end_y, want.ce[1]);
          if (clip_end_z !== want.ce[2]) report("clip_end_z", clip_end_z, want.ce[2]);
        end
      end
      if (start && !busy) begin
        s[0] = start_x; s[1] = start_y; s[2] = start_z;
        e[0] = end_x;   e[1] = end_y;   e[2] = end_z;
        clip_q.push_back(clip_segment(s, e));
      end
    end
    pending = clip_q.size();
  end

  initial begin
    fails = 0;
    pending = 0;
  end

endmodule

>>> tb/sv/tb_segment_box_clip_3d.sv
`timescale 1ns / 1ps
module tb_segment_box_clip_3d;
  import sbc3_pkg::*;

  // Generous bound on the whole run, in clock cycles.
  localparam int CYCLE_LIMIT = 400000;
  // Index past the six box registers; the block must ignore writes to it.
  localparam logic [2:0] REG_UNUSED = 3'd6;
  localparam longint ONE = 64'sd65536;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  coord_t      start_x = '0, start_y = '0, start_z = '0;
  coord_t      end_x = '0, end_y = '0, end_z = '0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic        done, accepted;
  coord_t      clip_start_x, clip_start_y, clip_start_z;
  coord_t      clip_end_x, clip_end_y, clip_end_z;
  int          fails, pending;
  int          cycles = 0;

  // The box the stimulus currently aims at, kept here to steer the random segments.
  longint cur_lo [3];
  longint cur_hi [3];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_box_clip_3d dut (.*);

  segment_box_clip_3d_checker checker_i (.*);

  // Watchdog: a run that never drains is a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic put_reg(logic [2:0] idx, longint val);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[31:0];
    @(posedge clk);
  endtask

  task automatic load_box(longint lx, longint ly, longint lz,
                          longint hx, longint hy, longint hz);
    put_reg(REG_MIN_X, lx);
    put_reg(REG_MIN_Y, ly);
    put_reg(REG_MIN_Z, lz);
    put_reg(REG_MAX_X, hx);
    put_reg(REG_MAX_Y, hy);
    put_reg(REG_MAX_Z, hz);
    cfg_we <= 1'b0;
    cur_lo[0] = lx; cur_lo[1] = ly; cur_lo[2] = lz;
    cur_hi[0] = hx; cur_hi[1] = hy; cur_hi[2] = hz;
  endtask

  // Waits until every outstanding result has been seen. The block answers every
  // beat, so an empty queue means the pipeline is empty as well.
  task automatic drain;
    start <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  // Presents one beat and holds it until the block takes it. Busy is sampled at
  // the falling edge so the decision never races the rising edge.
  task automatic seg(longint sx, longint sy, longint sz, longint ex, longint ey, longint ez);
    logic b;
    start <= 1'b1;
    start_x <= sx[31:0]; start_y <= sy[31:0]; start_z <= sz[31:0];
    end_x <= ex[31:0];   end_y <= ey[31:0];   end_z <= ez[31:0];
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
  endtask

  function automatic longint clamp32(longint v);
    if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  // A coordinate that lands inside, on, or past the slab, now and then anywhere.
  function automatic longint pick_coord(int a);
    longint span;
    longint lo;
    longint hi;
    lo = (cur_lo[a] < cur_hi[a]) ? cur_lo[a] : cur_hi[a];
    hi = (cur_lo[a] < cur_hi[a]) ? cur_hi[a] : cur_lo[a];
    span = (hi - lo) + 64'sd16;
    case ($urandom_range(0, 9))
      0: return longint'(signed'(32'($urandom)));
      1: return cur_lo[a];
      2: return cur_hi[a];
      default: return clamp32(lo - span + longint'($urandom_range(0, 1000000)) * (3 * span)
                              / 1000000);
    endcase
  endfunction

  // Random box: centered anywhere, spans from a few units to most of the range,
  // sometimes flat on an axis and sometimes inverted on one.
  task automatic random_box(bit may_invert);
    longint lo [3];
    longint hi [3];
    longint c;
    longint h;
    for (int a = 0; a < 3; a++) begin
      c = longint'(signed'(32'($urandom))) / (64'sd1 << $urandom_range(1, 12));
      h = longint'($urandom_range(0, 32'h3FFF_FFFF)) >> $urandom_range(0, 20);
      if ($urandom_range(0, 9) == 0) h = 0;
      lo[a] = clamp32(c - h);
      hi[a] = clamp32(c + h);
    end
    if (may_invert) begin
      c = lo[1];
      lo[1] = hi[1] + 1;
      hi[1] = c;
    end
    load_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
  endtask

  // Random segments in bursts with gaps; most are steered around the box.
  task automatic random_burst(int count);
    int left;
    int blen;
    longint s [3];
    longint e [3];
    left = count;
    while (left > 0) begin
      blen = $urandom_range(1, 24);
      while (blen > 0 && left > 0) begin
        for (int a = 0; a < 3; a++) begin
          if ($urandom_range(0, 4) == 0) begin
            s[a] = longint'(signed'(32'($urandom)));
            e[a] = longint'(signed'(32'($urandom)));
          end else begin
            s[a] = pick_coord(a);
            e[a] = ($urandom_range(0, 11) == 0) ? s[a] : pick_coord(a);
          end
        end
        seg(s[0], s[1], s[2], e[0], e[1], e[2]);
        blen--;
        left--;
      end
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  initial begin
    longint tn;
    longint mn;
    longint mx;
    tn = 10 * ONE;
    mn = -64'sh8000_0000;
    mx = 64'sh7FFF_FFFF;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The box after reset is empty: everything must be rejected.
    seg(0, 0, 0, ONE, ONE, ONE);
    seg(mn, mn, mn, mx, mx, mx);
    seg(mx, mx, mx, mx, mx, mx);
    drain();

    // Cube of side 20 around the origin: inside, crossings of every bound in
    // both directions, wholly outside on either side, and flat segments.
    load_box(-tn, -tn, -tn, tn, tn, tn);
    seg(-ONE, 2 * ONE, 3 * ONE, 4 * ONE, -5 * ONE, 6 * ONE);
    seg(-20 * ONE, 0, 0, 20 * ONE, ONE, -ONE);
    seg(20 * ONE, ONE, -ONE, -20 * ONE, 0, 0);
    seg(0, -30 * ONE, 5, 7, 30 * ONE, -3);
    seg(ONE, 30 * ONE, 2, -3, -30 * ONE, 9);
    seg(-3, 9, -15 * ONE, 4, 8, 15 * ONE);
    seg(-3, 9, 15 * ONE, 4, 8, -15 * ONE);
    seg(-40 * ONE, 0, 0, -11 * ONE, 0, 0);
    seg(11 * ONE, 0, 0, 40 * ONE, 0, 0);
    seg(0, 11 * ONE, 0, 0, 12 * ONE, 0);
    seg(0, 0, -12 * ONE, 0, 0, -11 * ONE);
    seg(5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE, 5 * ONE);
    seg(tn, -tn, tn, tn, -tn, tn);
    seg(tn + 1, 0, 0, tn + 1, ONE, ONE);
    seg(mn, mn, mn, mx, mx, mx);
    seg(mx, mn, mx, mn, mx, mn);
    seg(-30 * ONE, -30 * ONE, -30 * ONE, 30 * ONE, 31 * ONE, 29 * ONE);
    seg(mn, 0, 0, mx, 0, 0);
    drain();

    // Whole range as the box, with an ignored write to an unused index between.
    load_box(mn, mn, mn, mx, mx, mx);
    put_reg(REG_UNUSED, 0);
    cfg_we <= 1'b0;
    seg(mn, mn, mn, mx, mx, mx);
    seg(mx, mx, mx, mn, mn, mn);
    seg(mx, mn, 0, mx, mn, -1);
    drain();

    // Flat slabs at the extremes of the range on x and y, and at zero on z.
    load_box(mx, mn, 0, mx, mn, 0);
    seg(mn, mn, -ONE, mx, mx, ONE);
    seg(mx, mn, 0, mx, mn, 0);
    seg(mx, mx, mn, mn, mn, mx);
    drain();

    // Random phases, each with its own box; one has an inverted y slab.
    for (int ph = 0; ph < 8; ph++) begin
      random_box(ph == 5);
      random_burst(50);
      // Hold the sender until the pipeline has emptied, then carry on.
      if (ph == 2) drain();
      random_burst(50);
      drain();
    end

    start <= 1'b0;
    repeat (TOTAL_LAT + 20) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
